// ----- hw/rtl/uart_dual_ring_buffer_top_macros.svh -----
// Assertion helpers for the buffered UART front end.
`ifndef UART_DUAL_RING_BUFFER_TOP_MACROS_SVH
`define UART_DUAL_RING_BUFFER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// The expression must never be true outside reset.
`define UDRB_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define UDRB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define UDRB_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`define UDRB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- hw/rtl/udrb_pkg.sv -----
package udrb_pkg;

    // Buffer geometry.
    localparam int DEPTH  = 128;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int LVL_W  = $clog2(DEPTH + 1);
    localparam int FILL_W = 8;

    // Event codes carried in tuser.
    typedef enum logic [1:0] {
        CMD_LINE_RX    = 2'd0,
        CMD_HOST_READ  = 2'd1,
        CMD_HOST_WRITE = 2'd2,
        CMD_TX_READY   = 2'd3
    } t_cmd;

    // Result status codes.
    typedef enum logic [1:0] {
        STAT_OK          = 2'd0,
        STAT_RX_EMPTY    = 2'd1,
        STAT_TX_FULL     = 2'd2,
        STAT_RX_OVERFLOW = 2'd3
    } t_status;

    // Status of one ring buffer as seen by the control logic.
    typedef struct packed {
        logic             full;
        logic             empty;
        logic [LVL_W-1:0] level;
    } t_ring_stat;

    // Control for one ring buffer.
    typedef struct packed {
        logic push;
        logic pop;
    } t_ring_ctrl;

endpackage

// ----- hw/rtl/uart_dual_ring_buffer_top.sv -----
// Path: each event result is registered in the pending stage and then in the output
// stage, which drives m_axis; a stalled output holds the pending stage.
// Throughput: one event per cycle while results are taken; memory reads use the
// registered read port of each ring, so an event waits only while both stages are full.
// Reset: synchronous, active low; clears pointers, fill counts, the interrupt
// enable and both valid stages. Buffer contents are left as they are.
module uart_dual_ring_buffer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [1:0]  s_axis_tuser,   // [1:0] command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // [1:0] status, [9:2] read_data, [10] send_valid,
                                        // [18:11] send_data, [19] ready_irq_enable,
                                        // [27:20] rx_fill, [35:28] tx_fill, [39:36] zero
);
    `include "uart_dual_ring_buffer_top_macros.svh"
    import udrb_pkg::*;

    t_cmd       cmd;
    logic       in_xfer;
    logic       pend_move;
    t_ring_ctrl rx_ctrl, tx_ctrl;
    t_ring_stat rx_stat, tx_stat;
    logic [7:0] rx_q, tx_q;

    logic             r_irq_on, n_irq_on;
    t_status          n_status;
    logic [LVL_W-1:0] n_rx_level, n_tx_level;

    // Pending stage: the event has been applied, read data is on its way.
    logic              r_pend;
    t_status           r_pend_status;
    logic              r_pend_rd;
    logic              r_pend_send;
    logic              r_pend_irq;
    logic [FILL_W-1:0] r_pend_rx_fill;
    logic [FILL_W-1:0] r_pend_tx_fill;

    // Output stage.
    logic        r_out_valid;
    logic [39:0] r_out_data;

    assign cmd           = t_cmd'(s_axis_tuser);
    assign pend_move     = r_pend && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_pend || pend_move;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    // Decode the event against the buffer state.
    always_comb begin
        rx_ctrl    = '0;
        tx_ctrl    = '0;
        n_status   = STAT_OK;
        n_irq_on   = r_irq_on;
        n_rx_level = rx_stat.level;
        n_tx_level = tx_stat.level;
        case (cmd)
            CMD_LINE_RX: begin
                if (rx_stat.full) begin
                    n_status = STAT_RX_OVERFLOW;
                end else begin
                    rx_ctrl.push = in_xfer;
                    n_rx_level   = rx_stat.level + 1'b1;
                end
            end
            CMD_HOST_READ: begin
                if (rx_stat.empty) begin
                    n_status = STAT_RX_EMPTY;
                end else begin
                    rx_ctrl.pop = in_xfer;
                    n_rx_level  = rx_stat.level - 1'b1;
                end
            end
            CMD_HOST_WRITE: begin
                if (tx_stat.full) begin
                    n_status = STAT_TX_FULL;
                end else begin
                    tx_ctrl.push = in_xfer;
                    n_tx_level   = tx_stat.level + 1'b1;
                    n_irq_on     = 1'b1;
                end
            end
            CMD_TX_READY: begin
                if (tx_stat.empty) begin
                    n_irq_on = 1'b0;
                end else begin
                    tx_ctrl.pop = in_xfer;
                    n_tx_level  = tx_stat.level - 1'b1;
                end
            end
            default: begin
                n_status = STAT_OK;
            end
        endcase
    end

    udrb_ring u_rx_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (rx_ctrl),
        .i_wdata (s_axis_tdata),
        .o_rdata (rx_q),
        .o_stat  (rx_stat)
    );

    udrb_ring u_tx_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (tx_ctrl),
        .i_wdata (s_axis_tdata),
        .o_rdata (tx_q),
        .o_stat  (tx_stat)
    );

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_irq_on    <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_irq_on <= n_irq_on;
            end
            if (in_xfer) begin
                r_pend <= 1'b1;
            end else if (pend_move) begin
                r_pend <= 1'b0;
            end
            if (pend_move) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload; read bytes are taken from the ring read registers on the move.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_pend_status  <= n_status;
            r_pend_rd      <= rx_ctrl.pop;
            r_pend_send    <= tx_ctrl.pop;
            r_pend_irq     <= n_irq_on;
            r_pend_rx_fill <= FILL_W'(n_rx_level);
            r_pend_tx_fill <= FILL_W'(n_tx_level);
        end
        if (pend_move) begin
            r_out_data <= {4'd0,
                           r_pend_tx_fill,
                           r_pend_rx_fill,
                           r_pend_irq,
                           (r_pend_send ? tx_q : 8'd0),
                           r_pend_send,
                           (r_pend_rd ? rx_q : 8'd0),
                           r_pend_status};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    `UDRB_ASSERT_NEVER(a_rx_full_and_empty, i_clk, i_rst_n, rx_stat.full && rx_stat.empty, "rx ring both full and empty")
    `UDRB_ASSERT_NEVER(a_tx_over_depth, i_clk, i_rst_n, tx_stat.level > LVL_W'(DEPTH), "tx level beyond depth")
    `UDRB_ASSERT_NEXT(a_write_sets_irq, i_clk, i_rst_n, tx_ctrl.push, r_irq_on && !tx_stat.empty, "accepted host write did not arm interrupt")

endmodule

// ----- hw/rtl/udrb_ring.sv -----
module udrb_ring (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  udrb_pkg::t_ring_ctrl  i_ctrl,
    input  logic [7:0]            i_wdata,
    output logic [7:0]            o_rdata,
    output udrb_pkg::t_ring_stat  o_stat
);
    import udrb_pkg::*;

    logic [7:0]       r_mem [DEPTH];
    logic [7:0]       r_rdata;
    logic [PTR_W-1:0] r_head, n_head;
    logic [PTR_W-1:0] r_tail, n_tail;
    logic [LVL_W-1:0] r_level, n_level;

    // Pointer and level update; the caller only pushes when not full and pops when not empty.
    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_level = r_level;
        if (i_ctrl.push) begin
            n_head  = (r_head == PTR_W'(DEPTH - 1)) ? '0 : r_head + 1'b1;
            n_level = r_level + 1'b1;
        end
        if (i_ctrl.pop) begin
            n_tail  = (r_tail == PTR_W'(DEPTH - 1)) ? '0 : r_tail + 1'b1;
            n_level = r_level - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_level <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_level <= n_level;
        end
    end

    // Storage: one write port at the head, registered read at the tail.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            r_mem[r_head] <= i_wdata;
        end
        if (i_ctrl.pop) begin
            r_rdata <= r_mem[r_tail];
        end
    end

    assign o_rdata      = r_rdata;
    assign o_stat.level = r_level;
    assign o_stat.empty = (r_level == '0);
    assign o_stat.full  = (r_level == LVL_W'(DEPTH));

endmodule

// ----- test/tb.sv -----
module tb;
    import udrb_pkg::*;

    // One event as the host side presents it.
    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] data;
    } t_uart_event;

    // One result as the block reports it.
    typedef struct packed {
        t_status    status;
        logic [7:0] read_data;
        logic       send_valid;
        logic [7:0] send_data;
        logic       irq_enable;
        logic [7:0] rx_fill;
        logic [7:0] tx_fill;
    } t_uart_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] data_byte
    logic [1:0]  s_axis_tuser = 2'b00;   // [1:0] command
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;           // [1:0] status, [9:2] read_data, [10] send_valid,
                                         // [18:11] send_data, [19] ready_irq_enable,
                                         // [27:20] rx_fill, [35:28] tx_fill, [39:36] zero

    // Events waiting to be driven and results waiting to be seen.
    t_uart_event  uart_events[$];
    t_uart_result expected_results[$];

    // Shadow copy of both rings and the interrupt enable.
    logic [7:0] rx_ring[DEPTH];
    logic [7:0] tx_ring[DEPTH];
    int rx_wr_pos = 0;
    int rx_rd_pos = 0;
    int tx_wr_pos = 0;
    int tx_rd_pos = 0;
    int rx_count = 0;
    int tx_count = 0;
    logic irq_on = 1'b0;

    // Fill levels as the stimulus generator expects them when it queues events.
    int rx_planned = 0;
    int tx_planned = 0;

    int errors = 0;
    int results_checked = 0;
    int cmd_seen[4] = '{0, 0, 0, 0};
    int status_seen[4] = '{0, 0, 0, 0};

    // Handshake pacing state for both sides.
    int  send_wait = 0;
    bit  send_calm = 1'b0;
    int  send_run = 0;
    int  take_wait = 0;
    int  take_draw = 0;
    bit  take_calm = 1'b0;
    int  take_run = 0;

    t_uart_event  next_ev;
    t_uart_result want;

    uart_dual_ring_buffer_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #10 i_clk = ~i_clk;

    // Idle time for one item; runs with no idling alternate with random gaps.
    function automatic int draw_wait(inout bit calm, inout int run_left);
        if (run_left == 0) begin
            calm = ($urandom_range(0, 2) == 0);
            run_left = $urandom_range(8, 40);
        end else begin
            run_left--;
        end
        return calm ? 0 : $urandom_range(0, 13);
    endfunction

    // Queue one event and track the levels it should leave behind.
    function automatic void add_event(input t_cmd cmd, input logic [7:0] data);
        t_uart_event ev;
        ev.cmd = cmd;
        ev.data = data;
        uart_events.push_back(ev);
        case (cmd)
            CMD_LINE_RX:    if (rx_planned < DEPTH) rx_planned++;
            CMD_HOST_READ:  if (rx_planned > 0) rx_planned--;
            CMD_HOST_WRITE: if (tx_planned < DEPTH) tx_planned++;
            default:        if (tx_planned > 0) tx_planned--;
        endcase
    endfunction

    function automatic void add_random_event();
        add_event(t_cmd'($urandom_range(0, 3)), 8'($urandom));
    endfunction

    // Work out the result of one accepted event and update the shadow state.
    function automatic void predict_uart_event(input t_cmd cmd, input logic [7:0] data);
        t_uart_result r;
        r = '0;
        r.status = STAT_OK;
        case (cmd)
            CMD_LINE_RX: begin
                if (rx_count >= DEPTH) begin
                    r.status = STAT_RX_OVERFLOW;
                end else begin
                    rx_ring[rx_wr_pos] = data;
                    rx_wr_pos = (rx_wr_pos + 1) % DEPTH;
                    rx_count++;
                end
            end
            CMD_HOST_READ: begin
                if (rx_count == 0) begin
                    r.status = STAT_RX_EMPTY;
                end else begin
                    r.read_data = rx_ring[rx_rd_pos];
                    rx_rd_pos = (rx_rd_pos + 1) % DEPTH;
                    rx_count--;
                end
            end
            CMD_HOST_WRITE: begin
                if (tx_count >= DEPTH) begin
                    r.status = STAT_TX_FULL;
                end else begin
                    tx_ring[tx_wr_pos] = data;
                    tx_wr_pos = (tx_wr_pos + 1) % DEPTH;
                    tx_count++;
                    irq_on = 1'b1;
                end
            end
            default: begin
                // An idle transmitter with nothing to send turns its interrupt off.
                if (tx_count > 0) begin
                    r.send_valid = 1'b1;
                    r.send_data = tx_ring[tx_rd_pos];
                    tx_rd_pos = (tx_rd_pos + 1) % DEPTH;
                    tx_count--;
                end else begin
                    irq_on = 1'b0;
                end
            end
        endcase
        r.irq_enable = irq_on;
        r.rx_fill = 8'(rx_count);
        r.tx_fill = 8'(tx_count);
        cmd_seen[cmd]++;
        status_seen[r.status]++;
        expected_results.push_back(r);
    endfunction

    function automatic void check_field(input string name, input logic [7:0] exp_val,
                                        input logic [7:0] got_val);
        if (got_val !== exp_val) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val,
                     got_val);
            errors++;
        end
    endfunction

    // Event driver; also feeds every accepted event to the predictor.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_uart_event(t_cmd'(s_axis_tuser), s_axis_tdata);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_wait > 0) begin
                    s_axis_tvalid <= 1'b0;
                    send_wait <= send_wait - 1;
                end else if (uart_events.size() != 0) begin
                    next_ev = uart_events.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser <= next_ev.cmd;
                    s_axis_tdata <= next_ev.data;
                    send_wait <= draw_wait(send_calm, send_run);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver back-pressure.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result with no event pending, expected none, actual %h",
                             $time, m_axis_tdata);
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    results_checked++;
                    check_field("status", 8'(want.status), 8'(m_axis_tdata[1:0]));
                    check_field("read_data", want.read_data, m_axis_tdata[9:2]);
                    check_field("send_valid", 8'(want.send_valid), 8'(m_axis_tdata[10]));
                    check_field("send_data", want.send_data, m_axis_tdata[18:11]);
                    check_field("ready_irq_enable", 8'(want.irq_enable),
                                8'(m_axis_tdata[19]));
                    check_field("rx_fill", want.rx_fill, m_axis_tdata[27:20]);
                    check_field("tx_fill", want.tx_fill, m_axis_tdata[35:28]);
                    check_field("padding", 8'h00, 8'(m_axis_tdata[39:36]));
                end
                take_draw = draw_wait(take_calm, take_run);
                if (take_draw > 0) begin
                    m_axis_tready <= 1'b0;
                    take_wait <= take_draw - 1;
                end else begin
                    m_axis_tready <= 1'b1;
                end
            end else if (!m_axis_tready) begin
                if (take_wait > 0) begin
                    take_wait <= take_wait - 1;
                end else begin
                    m_axis_tready <= 1'b1;
                end
            end
        end
    end

    // Stimulus, end of run and verdict.
    initial begin
        // Directed events: empty reads and idle transmitter first, then byte extremes.
        add_event(CMD_HOST_READ, 8'hFF);
        add_event(CMD_TX_READY, 8'hFF);
        add_event(CMD_LINE_RX, 8'h00);
        add_event(CMD_LINE_RX, 8'hFF);
        add_event(CMD_LINE_RX, 8'hA5);
        add_event(CMD_HOST_READ, 8'h00);
        add_event(CMD_HOST_READ, 8'h5A);
        add_event(CMD_HOST_READ, 8'h00);
        add_event(CMD_HOST_READ, 8'h00);
        add_event(CMD_HOST_WRITE, 8'h00);
        add_event(CMD_HOST_WRITE, 8'hFF);
        add_event(CMD_HOST_WRITE, 8'h5A);
        add_event(CMD_TX_READY, 8'h00);
        add_event(CMD_TX_READY, 8'hA5);
        add_event(CMD_TX_READY, 8'h00);
        add_event(CMD_TX_READY, 8'h00);
        add_event(CMD_TX_READY, 8'h00);
        add_event(CMD_LINE_RX, 8'h3C);
        add_event(CMD_HOST_WRITE, 8'hC3);
        add_event(CMD_HOST_READ, 8'h00);
        add_event(CMD_TX_READY, 8'h00);

        // Fill both rings to the top with some noise mixed in.
        while (rx_planned < DEPTH || tx_planned < DEPTH) begin
            if ($urandom_range(0, 9) == 0) begin
                add_random_event();
            end else if (rx_planned < DEPTH && (tx_planned >= DEPTH || $urandom_range(0, 1)))
            begin
                add_event(CMD_LINE_RX, 8'($urandom));
            end else begin
                add_event(CMD_HOST_WRITE, 8'($urandom));
            end
        end
        // Line bytes into a full receive ring are dropped; writes to a full ring refused.
        repeat (3) add_event(CMD_LINE_RX, 8'($urandom));
        repeat (3) add_event(CMD_HOST_WRITE, 8'($urandom));
        repeat (30) add_random_event();

        // Drain part of both rings, then a few more reads and ready events.
        while ((rx_planned > 0 || tx_planned > 0) && uart_events.size() < 360) begin
            if ($urandom_range(0, 9) == 0) begin
                add_random_event();
            end else if (rx_planned > 0 && (tx_planned == 0 || $urandom_range(0, 1))) begin
                add_event(CMD_HOST_READ, 8'($urandom));
            end else begin
                add_event(CMD_TX_READY, 8'($urandom));
            end
        end
        repeat (2) add_event(CMD_HOST_READ, 8'($urandom));
        repeat (2) add_event(CMD_TX_READY, 8'($urandom));
        repeat (30) add_random_event();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (uart_events.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Sent %0d line bytes, %0d reads, %0d writes, %0d ready events.",
                 cmd_seen[CMD_LINE_RX], cmd_seen[CMD_HOST_READ], cmd_seen[CMD_HOST_WRITE],
                 cmd_seen[CMD_TX_READY]);
        $display("Checked %0d results: %0d empty reads, %0d full writes, %0d dropped bytes.",
                 results_checked, status_seen[STAT_RX_EMPTY], status_seen[STAT_TX_FULL],
                 status_seen[STAT_RX_OVERFLOW]);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #5000000;
        $display("simulation failed");
        $finish;
    end

endmodule
